// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rsq_pkg.sv -----
// Package for the rotated sprite quad and hit test block.
// Holds widths, codes, the queue entry type and the sine table builder; no dependencies.
package rsq_pkg;

    // Sine table geometry: DEPTH+1 entries of a quarter wave in Q1.15.
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SCALE_W          = 14 + SINE_IDX_W;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Datapath widths.
    localparam int C_W  = 16;   // signed sine / cosine
    localparam int OP_W = 33;   // multiplier operand: half size or point offset
    localparam int P_W  = 49;   // one product
    localparam int S_W  = 50;   // sum of two products
    localparam int R_W  = 35;   // sum after the Q.31 to Q16.16 rounding shift
    localparam int F_W  = 36;   // center plus rotated offset, before saturation

    localparam int ROUND_HALF = 16384;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // Decoupling queue between front and back.
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Vertex sequencing: bit i set means the corner sign is minus for vertex i.
    localparam int VTX_W = 3;
    localparam logic [VTX_W-1:0] LAST_VERTEX = 3'd5;
    localparam logic [5:0] CORNER_NEG_X = 6'b001101;
    localparam logic [5:0] CORNER_NEG_Y = 6'b101001;

    typedef enum logic {
        ACT_QUAD = 1'b0,
        ACT_HIT  = 1'b1
    } t_action;

    typedef struct packed {
        t_action                 action;
        logic signed [31:0]      pos_x;
        logic signed [31:0]      pos_y;
        logic signed [P_W-1:0]   p_ac;
        logic signed [P_W-1:0]   p_as;
        logic signed [P_W-1:0]   p_bc;
        logic signed [P_W-1:0]   p_bs;
        logic                    hit;
    } t_entry;

    typedef logic [15:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    localparam logic [63:0] TAYLOR_DIV [1:7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    // Builds the quarter-wave table at elaboration: Taylor series to x^15 in Q2.30,
    // each term truncated, then rounded half up to Q1.15 and clipped.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 7; n++) begin
                term = (term * x2) >> 30;
                term = term / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum + 64'd16384) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[k] = v[15:0];
        end
        return rom;
    endfunction

endpackage

// ----- rtl/rsq_if.sv -----
// Channel interfaces of the rotated sprite quad and hit test block.
// The input item channel and the result channel; no dependencies.
interface rsq_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        angle;
    logic [30:0]        size_x;
    logic [30:0]        size_y;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;

    modport source (
        output valid, action, pos_x, pos_y, angle, size_x, size_y, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, action, pos_x, pos_y, angle, size_x, size_y, point_x, point_y,
        output ready
    );
endinterface

interface rsq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic               hit;
    logic               last;

    modport source (output valid, vert_x, vert_y, hit, last, input ready);
    modport sink (input valid, vert_x, vert_y, hit, last, output ready);
endinterface

// ----- rtl/rsq_front.sv -----
// Front part: accepts items, looks up sine and cosine, forms the four products.
// Depends on rsq_pkg and rsq_in_if; feeds rsq_queue with one entry per item.
module rsq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rsq_in_if.sink          i_item,
    input  logic            i_pop,
    output logic            o_push,
    output rsq_pkg::t_entry o_entry
);
    import rsq_pkg::*;

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    // Maps a binary angle to the table entry holding |sin|.
    function automatic logic [SINE_IDX_W-1:0] sine_addr(input logic [15:0] a);
        logic [SCALE_W-1:0]    scaled;
        logic [SINE_IDX_W-1:0] idx;
        scaled = SCALE_W'(a[13:0]) * SCALE_W'(SINE_TABLE_DEPTH);
        idx = scaled[SCALE_W-1 -: SINE_IDX_W];
        return a[14] ? (SINE_IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
    endfunction

    logic [QCNT_W-1:0] r_credits;
    logic [QCNT_W-1:0] n_credits;
    logic              accept;

    logic signed [OP_W-1:0] n_dx;
    logic signed [OP_W-1:0] n_dy;
    logic [15:0]            n_angle;
    logic [15:0]            n_cos_angle;

    logic                    r0_valid;
    t_action                 r0_action;
    logic signed [31:0]      r0_pos_x;
    logic signed [31:0]      r0_pos_y;
    logic [30:0]             r0_size_x;
    logic [30:0]             r0_size_y;
    logic signed [OP_W-1:0]  r0_opa;
    logic signed [OP_W-1:0]  r0_opb;
    logic [SINE_IDX_W-1:0]   r0_sin_addr;
    logic [SINE_IDX_W-1:0]   r0_cos_addr;
    logic                    r0_sin_neg;
    logic                    r0_cos_neg;

    logic                    r1_valid;
    t_action                 r1_action;
    logic signed [31:0]      r1_pos_x;
    logic signed [31:0]      r1_pos_y;
    logic [30:0]             r1_size_x;
    logic [30:0]             r1_size_y;
    logic signed [OP_W-1:0]  r1_opa;
    logic signed [OP_W-1:0]  r1_opb;
    logic [15:0]             r1_sin_mag;
    logic [15:0]             r1_cos_mag;
    logic                    r1_sin_neg;
    logic                    r1_cos_neg;

    logic signed [C_W-1:0]   n_c;
    logic signed [C_W-1:0]   n_s;
    logic signed [P_W-1:0]   n_p_ac;
    logic signed [P_W-1:0]   n_p_as;
    logic signed [P_W-1:0]   n_p_bc;
    logic signed [P_W-1:0]   n_p_bs;

    logic                    r2_valid;
    t_action                 r2_action;
    logic signed [31:0]      r2_pos_x;
    logic signed [31:0]      r2_pos_y;
    logic [30:0]             r2_size_x;
    logic [30:0]             r2_size_y;
    logic signed [P_W-1:0]   r2_p_ac;
    logic signed [P_W-1:0]   r2_p_as;
    logic signed [P_W-1:0]   r2_p_bc;
    logic signed [P_W-1:0]   r2_p_bs;

    logic signed [S_W-1:0]   n_ux;
    logic signed [S_W-1:0]   n_uy;
    logic signed [S_W-1:0]   n_lx;
    logic signed [S_W-1:0]   n_ly;
    logic                    n_hit;

    logic                    r3_valid;
    t_entry                  r3_entry;

    // Every item in flight holds a queue slot, so the pipeline never stalls.
    always_comb begin
        i_item.ready = (r_credits != '0);
        accept = i_item.valid && i_item.ready;
        n_credits = r_credits + QCNT_W'(i_pop) - QCNT_W'(accept);

        n_dx = i_item.point_x - i_item.pos_x;
        n_dy = i_item.point_y - i_item.pos_y;
        n_angle = (t_action'(i_item.action) == ACT_HIT) ? (16'h0000 - i_item.angle)
                                                       : i_item.angle;
        n_cos_angle = n_angle + QUARTER_TURN;
    end

    always_comb begin
        n_c = r1_cos_neg ? -$signed(r1_cos_mag) : $signed(r1_cos_mag);
        n_s = r1_sin_neg ? -$signed(r1_sin_mag) : $signed(r1_sin_mag);
        n_p_ac = r1_opa * n_c;
        n_p_as = r1_opa * n_s;
        n_p_bc = r1_opb * n_c;
        n_p_bs = r1_opb * n_s;
    end

    always_comb begin
        n_ux = r2_p_ac - r2_p_bs;
        n_uy = r2_p_bc + r2_p_as;
        n_lx = $signed({5'b00000, r2_size_x, 14'b0});
        n_ly = $signed({5'b00000, r2_size_y, 14'b0});
        n_hit = (n_ux >= -n_lx) && (n_ux <= n_lx) && (n_uy >= -n_ly) && (n_uy <= n_ly);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credits <= QCNT_W'(QDEPTH);
            r0_valid  <= 1'b0;
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r3_valid  <= 1'b0;
        end else begin
            r_credits <= n_credits;
            r0_valid  <= accept;
            r1_valid  <= r0_valid;
            r2_valid  <= r1_valid;
            r3_valid  <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_action   <= t_action'(i_item.action);
        r0_pos_x    <= i_item.pos_x;
        r0_pos_y    <= i_item.pos_y;
        r0_size_x   <= i_item.size_x;
        r0_size_y   <= i_item.size_y;
        if (t_action'(i_item.action) == ACT_HIT) begin
            r0_opa <= n_dx;
            r0_opb <= n_dy;
        end else begin
            r0_opa <= $signed({3'b000, i_item.size_x[30:1]});
            r0_opb <= $signed({3'b000, i_item.size_y[30:1]});
        end
        r0_sin_addr <= sine_addr(n_angle);
        r0_cos_addr <= sine_addr(n_cos_angle);
        r0_sin_neg  <= n_angle[15];
        r0_cos_neg  <= n_cos_angle[15];

        // Two read ports of the sine ROM, registered.
        r1_sin_mag  <= SINE_ROM[r0_sin_addr];
        r1_cos_mag  <= SINE_ROM[r0_cos_addr];
        r1_sin_neg  <= r0_sin_neg;
        r1_cos_neg  <= r0_cos_neg;
        r1_action   <= r0_action;
        r1_pos_x    <= r0_pos_x;
        r1_pos_y    <= r0_pos_y;
        r1_size_x   <= r0_size_x;
        r1_size_y   <= r0_size_y;
        r1_opa      <= r0_opa;
        r1_opb      <= r0_opb;

        r2_action   <= r1_action;
        r2_pos_x    <= r1_pos_x;
        r2_pos_y    <= r1_pos_y;
        r2_size_x   <= r1_size_x;
        r2_size_y   <= r1_size_y;
        r2_p_ac     <= n_p_ac;
        r2_p_as     <= n_p_as;
        r2_p_bc     <= n_p_bc;
        r2_p_bs     <= n_p_bs;

        r3_entry.action <= r2_action;
        r3_entry.pos_x  <= r2_pos_x;
        r3_entry.pos_y  <= r2_pos_y;
        r3_entry.p_ac   <= r2_p_ac;
        r3_entry.p_as   <= r2_p_as;
        r3_entry.p_bc   <= r2_p_bc;
        r3_entry.p_bs   <= r2_p_bs;
        r3_entry.hit    <= n_hit;
    end

    assign o_push  = r3_valid;
    assign o_entry = r3_entry;

endmodule

// ----- rtl/rsq_queue.sv -----
// Decoupling queue between the front and back parts.
// Depends on rsq_pkg for the entry type and depth.
module rsq_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rsq_pkg::t_entry i_entry,
    input  logic            i_pop,
    output rsq_pkg::t_entry o_head,
    output logic            o_empty
);
    import rsq_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);

endmodule

// ----- rtl/rsq_back.sv -----
// Back part: walks the six vertices of a quad entry or emits one hit result.
// Depends on rsq_pkg and rsq_out_if; drains rsq_queue.
module rsq_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsq_pkg::t_entry i_head,
    input  logic            i_empty,
    output logic            o_pop,
    rsq_out_if.source       o_res
);
    import rsq_pkg::*;

    function automatic logic [31:0] sat32(input logic signed [F_W-1:0] v);
        if (v[F_W-1:31] == {(F_W - 31){v[F_W-1]}}) begin
            return v[31:0];
        end
        return v[F_W-1] ? SAT_MIN : SAT_MAX;
    endfunction

    logic [VTX_W-1:0]      r_vtx;
    logic                  en_b1;
    logic                  en_b2;
    logic                  load_b1;
    logic                  is_last;
    logic                  neg_x;
    logic                  neg_y;
    logic signed [S_W-1:0] n_sum_x;
    logic signed [S_W-1:0] n_sum_y;

    logic                  r1_valid;
    logic signed [R_W-1:0] r1_rx;
    logic signed [R_W-1:0] r1_ry;
    logic signed [31:0]    r1_pos_x;
    logic signed [31:0]    r1_pos_y;
    logic                  r1_zero;
    logic                  r1_hit;
    logic                  r1_last;

    logic signed [F_W-1:0] n_full_x;
    logic signed [F_W-1:0] n_full_y;

    logic                  r2_valid;
    logic [31:0]           r2_vert_x;
    logic [31:0]           r2_vert_y;
    logic                  r2_hit;
    logic                  r2_last;

    always_comb begin
        en_b2   = !r2_valid || o_res.ready;
        en_b1   = !r1_valid || en_b2;
        load_b1 = en_b1 && !i_empty;
        is_last = (i_head.action == ACT_HIT) || (r_vtx == LAST_VERTEX);
        o_pop   = load_b1 && is_last;
        neg_x   = CORNER_NEG_X[r_vtx];
        neg_y   = CORNER_NEG_Y[r_vtx];

        // Rotated corner offset in Q.31 with the rounding half already added.
        n_sum_x = (neg_x ? -$signed(i_head.p_ac) : $signed(i_head.p_ac))
                + (neg_y ? $signed(i_head.p_bs) : -$signed(i_head.p_bs))
                + S_W'(ROUND_HALF);
        n_sum_y = (neg_y ? -$signed(i_head.p_bc) : $signed(i_head.p_bc))
                + (neg_x ? -$signed(i_head.p_as) : $signed(i_head.p_as))
                + S_W'(ROUND_HALF);

        n_full_x = r1_pos_x + r1_rx;
        n_full_y = r1_pos_y + r1_ry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx    <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (en_b1) begin
                r1_valid <= !i_empty;
            end
            if (load_b1) begin
                r_vtx <= is_last ? '0 : r_vtx + 1'b1;
            end
            if (en_b2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_b1) begin
            r1_rx    <= $signed(n_sum_x[S_W-1:15]);
            r1_ry    <= $signed(n_sum_y[S_W-1:15]);
            r1_pos_x <= i_head.pos_x;
            r1_pos_y <= i_head.pos_y;
            r1_zero  <= (i_head.action == ACT_HIT);
            r1_hit   <= (i_head.action == ACT_HIT) && i_head.hit;
            r1_last  <= is_last;
        end
        if (en_b2 && r1_valid) begin
            r2_vert_x <= r1_zero ? '0 : sat32(n_full_x);
            r2_vert_y <= r1_zero ? '0 : sat32(n_full_y);
            r2_hit    <= r1_hit;
            r2_last   <= r1_last;
        end
    end

    assign o_res.valid  = r2_valid;
    assign o_res.vert_x = $signed(r2_vert_x);
    assign o_res.vert_y = $signed(r2_vert_y);
    assign o_res.hit    = r2_hit;
    assign o_res.last   = r2_last;

endmodule

// ----- rtl/rotated_sprite_quad_and_hit_test.sv -----
// Rotated sprite quad builder and point-in-rotated-box hit test.
// Depends on rsq_pkg, rsq_if, rsq_front, rsq_queue and rsq_back.
//
// Usage: each transfer on i_item carries a sprite pose (center, binary angle,
// size in Q16.16) and an action. A quad action produces six vertex transfers
// on o_res, the triangle pair of the rotated sprite, with last set on the sixth.
// A hit action produces one transfer whose hit flag tells whether the test
// point lies inside the rotated box; its vertex fields read zero.
// Path: an accepted item passes four front stages, the queue and two back stages
// before its first result is valid. Throughput: while o_res.ready stays high and
// the queue holds entries, the back part emits one result per cycle, so a quad
// item gives six results in a row and a stream of hit items runs back to back.
// An eight-entry queue separates the front from the back; the front holds one
// slot for every item it has accepted, and i_item.ready drops only when all
// slots are taken. When the receiver stalls, the result on o_res holds and the
// back part stops, but the front keeps taking items until the queue fills.
// Reset (synchronous, active low) empties the pipelines and the queue; the sine
// table is a constant ROM and needs no fill after reset.
module rotated_sprite_quad_and_hit_test (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsq_in_if.sink    i_item,
    rsq_out_if.source o_res
);
    import rsq_pkg::*;

    logic   push;
    logic   pop;
    logic   empty;
    t_entry entry;
    t_entry head;

    // Front part: sine lookup and the four products of each item.
    rsq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_push  (push),
        .o_entry (entry)
    );

    // The queue lets the front run ahead while the back walks vertices.
    rsq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    // Back part: vertex sequencing, rounding, center offset and saturation.
    rsq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ----- rtl/rsq_checker.sv -----
// Port-level checker for the rotated sprite quad and hit test block.
// Depends on assert_macros.svh; attached to the top level by the bind below.
`include "assert_macros.svh"

module rsq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_vert_x,
    input logic [31:0] i_out_vert_y,
    input logic        i_out_hit,
    input logic        i_out_last
);

    logic        stall;
    logic        hit_out;
    logic        hit_ok;
    logic        mid_burst;
    logic [65:0] payload;

    assign stall     = i_out_valid && !i_out_ready;
    assign hit_out   = i_out_valid && i_out_hit;
    assign hit_ok    = i_out_last && (i_out_vert_x == 32'd0) && (i_out_vert_y == 32'd0);
    assign mid_burst = i_out_valid && i_out_ready && !i_out_last;
    assign payload   = {i_out_vert_x, i_out_vert_y, i_out_hit, i_out_last};

    // A stalled result stays offered.
    `RSQ_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, stall, i_out_valid, "valid dropped on stall")

    // A stalled result keeps its payload.
    `RSQ_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, stall, $stable(payload), "data changed on stall")

    // A hit result is a single, closing result with zero vertex fields.
    `RSQ_ASSERT_NOW(a_hit_shape, i_clk, i_rst_n, hit_out, hit_ok, "malformed hit result")

    // The vertices of one quad leave without gaps.
    `RSQ_ASSERT_NEXT(a_quad_no_gap, i_clk, i_rst_n, mid_burst, i_out_valid, "gap in vertex burst")

endmodule

bind rotated_sprite_quad_and_hit_test rsq_checker u_rsq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_vert_x (o_res.vert_x),
    .i_out_vert_y (o_res.vert_y),
    .i_out_hit    (o_res.hit),
    .i_out_last   (o_res.last)
);

// ----- verif/rsq_result_checker.sv -----
// Result checker for the rotated sprite quad and hit test block.
// Watches the rsq_in_if and rsq_out_if channels, predicts the results of every item
// from its own sine table and fixed-point arithmetic, and compares them in order; uses rsq_pkg.
`timescale 1ns / 1ps
module rsq_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rsq_in_if    i_item,
    rsq_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import rsq_pkg::*;

    // pi/2 in Q2.30, the argument scale of the quarter-wave table.
    localparam longint unsigned HALF_TURN_ARG = 64'd1686629713;
    localparam longint          HALF_LSB      = 64'sd16384;

    // Corner signs in emission order: (-,-),(+,+),(-,+),(-,-),(+,+),(+,-).
    localparam int SIGN_X [0:5] = '{-1, 1, -1, -1, 1, 1};
    localparam int SIGN_Y [0:5] = '{-1, 1, 1, -1, 1, -1};

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               hit;
        logic               last;
    } t_sprite_result;

    logic [15:0]    quarter_sine [0:SINE_TABLE_DEPTH];
    t_sprite_result owed_results [$];
    t_sprite_result want;
    int             fail_tally;

    // Appends one predicted result at the tail of the owed list.
    function automatic void owe_result(input t_sprite_result r);
        owed_results.insert(owed_results.size(), r);
    endfunction

    // Taylor series to the x^15 term in Q2.30, every term truncated, then
    // rounded half up to Q1.15 and clipped at the top.
    function automatic void fill_quarter_sine();
        longint unsigned arg;
        longint unsigned arg_sq;
        longint unsigned term;
        longint unsigned acc;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            arg    = (64'(k) * HALF_TURN_ARG + 64'(SINE_TABLE_DEPTH / 2))
                     / 64'(SINE_TABLE_DEPTH);
            arg_sq = (arg * arg) >> 30;
            term   = arg;
            acc    = arg;
            for (int n = 1; n <= 7; n++) begin
                term = ((term * arg_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - term : acc + term;
            end
            acc = (acc + 64'd16384) >> 15;
            quarter_sine[k] = (acc > 64'd32767) ? 16'd32767 : acc[15:0];
        end
    endfunction

    function automatic longint sine_of(logic [15:0] a);
        longint idx;
        longint mag;
        idx = (longint'(a[13:0]) * SINE_TABLE_DEPTH) >>> 14;
        mag = a[14] ? longint'(quarter_sine[SINE_TABLE_DEPTH - idx])
                    : longint'(quarter_sine[idx]);
        return a[15] ? -mag : mag;
    endfunction

    function automatic longint cosine_of(logic [15:0] a);
        logic [15:0] shifted;
        shifted = a + QUARTER_TURN;
        return sine_of(shifted);
    endfunction

    function automatic logic signed [31:0] clamp_word(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic void predict_sprite_results(
        t_action            act,
        logic signed [31:0] cx,
        logic signed [31:0] cy,
        logic [15:0]        ang,
        logic [30:0]        wx,
        logic [30:0]        wy,
        logic signed [31:0] tx,
        logic signed [31:0] ty
    );
        longint         c;
        longint         s;
        longint         ex;
        longint         ey;
        longint         dx;
        longint         dy;
        longint         ux;
        longint         uy;
        longint         lx;
        longint         ly;
        logic [15:0]    back;
        t_sprite_result r;
        if (act == ACT_QUAD) begin
            c = cosine_of(ang);
            s = sine_of(ang);
            for (int v = 0; v < 6; v++) begin
                ex     = SIGN_X[v] * longint'(wx >> 1);
                ey     = SIGN_Y[v] * longint'(wy >> 1);
                r.vx   = clamp_word(longint'(cx) + ((ex * c - ey * s + HALF_LSB) >>> 15));
                r.vy   = clamp_word(longint'(cy) + ((ey * c + ex * s + HALF_LSB) >>> 15));
                r.hit  = 1'b0;
                r.last = (v == 5);
                owe_result(r);
            end
        end else begin
            // Turn the offset back by the sprite's angle and compare at Q.31.
            back   = 16'd0 - ang;
            c      = cosine_of(back);
            s      = sine_of(back);
            dx     = longint'(tx) - longint'(cx);
            dy     = longint'(ty) - longint'(cy);
            ux     = dx * c - dy * s;
            uy     = dy * c + dx * s;
            lx     = longint'(wx) * 16384;
            ly     = longint'(wy) * 16384;
            r.vx   = '0;
            r.vy   = '0;
            r.hit  = (ux >= -lx) && (ux <= lx) && (uy >= -ly) && (uy <= ly);
            r.last = 1'b1;
            owe_result(r);
        end
    endfunction

    initial begin
        fill_quarter_sine();
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_item.valid && i_item.ready) begin
                predict_sprite_results(t_action'(i_item.action), i_item.pos_x, i_item.pos_y,
                                       i_item.angle, i_item.size_x, i_item.size_y,
                                       i_item.point_x, i_item.point_y);
            end
            if (i_res.valid && i_res.ready) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result: vert_x %0d vert_y %0d hit %0b last %0b",
                           i_res.vert_x, i_res.vert_y, i_res.hit, i_res.last);
                    fail_tally++;
                end else begin
                    want = owed_results.pop_front();
                    if (i_res.vert_x !== want.vx) begin
                        $error("vert_x: expected %0d, actual %0d", want.vx, i_res.vert_x);
                        fail_tally++;
                    end
                    if (i_res.vert_y !== want.vy) begin
                        $error("vert_y: expected %0d, actual %0d", want.vy, i_res.vert_y);
                        fail_tally++;
                    end
                    if (i_res.hit !== want.hit) begin
                        $error("hit: expected %0b, actual %0b", want.hit, i_res.hit);
                        fail_tally++;
                    end
                    if (i_res.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, i_res.last);
                        fail_tally++;
                    end
                end
            end
        end
        o_fail_count <= fail_tally;
        o_pending    <= owed_results.size();
    end

endmodule

// ----- verif/rotated_sprite_quad_and_hit_test_test.sv -----
// Top of the testbench for the rotated sprite quad and hit test block.
// Drives sprite poses into the block and gives the verdict; depends on rsq_pkg, rsq_if,
// rotated_sprite_quad_and_hit_test and rsq_result_checker.
`timescale 1ns / 1ps
module rotated_sprite_quad_and_hit_test_test;
    import rsq_pkg::*;

    localparam int RANDOM_ITEMS  = 211;
    // Results trail the last accepted item through the pipeline; the settle time
    // covers any stray transfer the block might still make after the expected ones.
    localparam int SETTLE_CYCLES = 24;
    // The slowest correct run is roughly 230 items of 6 results, each result
    // waiting out the longest receiver stall, plus sender gaps: well inside the limit.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int Q_ONE         = 65536;

    typedef struct {
        t_action            action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        angle;
        logic [30:0]        size_x;
        logic [30:0]        size_y;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_sprite_pose;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic accept_now = 1'b0;
    int   fail_count;
    int   owed_count;
    int   cycle_count;
    int   burst_left;
    int   run_left;
    int   stall_left;

    rsq_in_if  item_ch ();
    rsq_out_if res_ch ();

    rotated_sprite_quad_and_hit_test DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch)
    );

    // The checker sees every transfer on both channels; the top only reads
    // how many results are still owed and how many checks failed.
    rsq_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (owed_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver alternates runs of acceptance with short stalls. Now and
    // then a long run keeps ready high so results stream back to back, and
    // the eight-entry queue inside the block gets a chance to fill when a
    // stall lands on a quad burst.
    assign res_ch.ready = accept_now;

    always @(posedge i_clk) begin
        if (run_left > 0) begin
            accept_now <= 1'b1;
            run_left--;
        end else if (stall_left > 0) begin
            accept_now <= 1'b0;
            stall_left--;
        end else begin
            run_left   = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(0, 6);
            stall_left = $urandom_range(1, 4);
            accept_now <= 1'b1;
        end
    end

    function automatic t_sprite_pose make_pose(
        t_action            act,
        logic signed [31:0] px,
        logic signed [31:0] py,
        logic [15:0]        ang,
        logic [30:0]        sx,
        logic [30:0]        sy,
        logic signed [31:0] qx,
        logic signed [31:0] qy
    );
        t_sprite_pose p;
        p.action  = act;
        p.pos_x   = px;
        p.pos_y   = py;
        p.angle   = ang;
        p.size_x  = sx;
        p.size_y  = sy;
        p.point_x = qx;
        p.point_y = qy;
        return p;
    endfunction

    // Centers and points: mostly a moderate window around the origin, some
    // fully random words, and now and then a rail so saturation is reached.
    function automatic logic signed [31:0] random_coord();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return ($urandom_range(0, 1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end
        if (pick < 4) begin
            return $signed(32'($urandom));
        end
        return $signed(32'($urandom_range(0, 32'h0FFF_FFFF))) - 32'sh0800_0000;
    endfunction

    // Sizes: mostly up to 256.0, some full range, the maximum, and tiny ones
    // where the dropped odd bit of the half size matters.
    function automatic logic [30:0] random_length();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 31'h7FFF_FFFF;
        end
        if (pick == 1) begin
            return 31'($urandom_range(0, 3));
        end
        if (pick < 4) begin
            return 31'($urandom);
        end
        return 31'($urandom_range(0, 32'h00FF_FFFF));
    endfunction

    // A point within three quarters of the full size of the center on one
    // axis, so roughly half of these land inside the rotated box.
    function automatic logic signed [31:0] random_near(logic signed [31:0] center,
                                                        logic [30:0] length);
        longint reach;
        reach = longint'(length) * 3 / 4;
        return 32'(longint'(center) + longint'({32'h0, $urandom}) % (2 * reach + 1) - reach);
    endfunction

    function automatic t_sprite_pose random_pose();
        t_sprite_pose p;
        p.action = ($urandom_range(0, 1) == 1) ? ACT_HIT : ACT_QUAD;
        p.pos_x  = random_coord();
        p.pos_y  = random_coord();
        p.angle  = ($urandom_range(0, 7) == 0) ? {2'($urandom_range(0, 3)), 14'd0}
                                               : 16'($urandom);
        p.size_x = random_length();
        p.size_y = random_length();
        if (p.action == ACT_HIT && $urandom_range(0, 3) != 0) begin
            p.point_x = random_near(p.pos_x, p.size_x);
            p.point_y = random_near(p.pos_y, p.size_y);
        end else begin
            p.point_x = random_coord();
            p.point_y = random_coord();
        end
        return p;
    endfunction

    // Presents one pose and returns at the edge where it is transferred.
    // Within a burst valid stays high from one pose to the next; between
    // bursts it drops for a random gap before the next pose, so valid never
    // gets two assignments in the same step.
    task automatic push_pose(input t_sprite_pose p);
        int gap;
        if (burst_left == 0) begin
            item_ch.valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 8);
        end
        item_ch.valid   <= 1'b1;
        item_ch.action  <= p.action;
        item_ch.pos_x   <= p.pos_x;
        item_ch.pos_y   <= p.pos_y;
        item_ch.angle   <= p.angle;
        item_ch.size_x  <= p.size_x;
        item_ch.size_y  <= p.size_y;
        item_ch.point_x <= p.point_x;
        item_ch.point_y <= p.point_y;
        do begin
            @(posedge i_clk);
        end while (!item_ch.ready);
        burst_left--;
    endtask

    initial begin
        logic [15:0] turns [0:4];
        turns = '{16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};

        i_rst_n         <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.action  <= ACT_QUAD;
        item_ch.pos_x   <= '0;
        item_ch.pos_y   <= '0;
        item_ch.angle   <= '0;
        item_ch.size_x  <= '0;
        item_ch.size_y  <= '0;
        item_ch.point_x <= '0;
        item_ch.point_y <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Degenerate quad: all six vertices collapse onto the origin.
        push_pose(make_pose(ACT_QUAD, 0, 0, 16'h0000, 31'd0, 31'd0, 0, 0));
        // Odd sizes of a few LSBs: the half size drops the low bit.
        push_pose(make_pose(ACT_QUAD, Q_ONE, 2 * Q_ONE, 16'h0000, 31'd3, 31'd5, 0, 0));
        // Quadrant boundaries, the last code before a full turn, and 45 degrees.
        foreach (turns[i]) begin
            push_pose(make_pose(ACT_QUAD, 100 * Q_ONE, -50 * Q_ONE, turns[i],
                                31'(16 * Q_ONE), 31'(8 * Q_ONE), 0, 0));
        end
        // Largest size around the origin, then around both rails so the sums
        // saturate high and low.
        push_pose(make_pose(ACT_QUAD, 0, 0, 16'h2000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0));
        push_pose(make_pose(ACT_QUAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h1234,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0));
        push_pose(make_pose(ACT_QUAD, 32'sh8000_0000, 32'sh8000_0000, 16'h9ABC,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0));

        // Zero-size box with the point on its center: still a hit, bounds inclusive.
        push_pose(make_pose(ACT_HIT, 3 * Q_ONE, 4 * Q_ONE, 16'h5555, 31'd0, 31'd0,
                            3 * Q_ONE, 4 * Q_ONE));
        // At a quarter turn the y offset maps onto the x extent with a factor
        // of 32767, so this offset and width meet exactly on the boundary;
        // one LSB further is outside, and the mirrored offset is on the boundary.
        push_pose(make_pose(ACT_HIT, 5 * Q_ONE, -3 * Q_ONE, 16'h4000, 31'd65534, 31'(Q_ONE),
                            5 * Q_ONE, -3 * Q_ONE + 32768));
        push_pose(make_pose(ACT_HIT, 5 * Q_ONE, -3 * Q_ONE, 16'h4000, 31'd65534, 31'(Q_ONE),
                            5 * Q_ONE, -3 * Q_ONE + 32769));
        push_pose(make_pose(ACT_HIT, 5 * Q_ONE, -3 * Q_ONE, 16'h4000, 31'd65534, 31'(Q_ONE),
                            5 * Q_ONE, -3 * Q_ONE - 32768));
        push_pose(make_pose(ACT_HIT, 0, 0, 16'h0000, 31'(2 * Q_ONE), 31'(2 * Q_ONE),
                            Q_ONE, -Q_ONE));
        // Offsets that need the full 33 bits, in both directions.
        push_pose(make_pose(ACT_HIT, 32'sh8000_0000, 32'sh8000_0000, 16'h0000,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        push_pose(make_pose(ACT_HIT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h8000,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
        push_pose(make_pose(ACT_HIT, 0, 0, 16'h2000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                            32'sh4000_0000, 0));
        push_pose(make_pose(ACT_HIT, 7 * Q_ONE, 7 * Q_ONE, 16'hFFFF, 31'(10 * Q_ONE),
                            31'(4 * Q_ONE), 9 * Q_ONE, 8 * Q_ONE));

        repeat (RANDOM_ITEMS) begin
            push_pose(random_pose());
        end
        item_ch.valid <= 1'b0;

        // The owed count is registered in the checker, so it trails the last transfer.
        @(posedge i_clk);
        while (owed_count != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
